FILE: sv/fic_pkg.sv
package fic_pkg;

   localparam int unsigned SIZE_REG_W  = 24;
   localparam int unsigned CRC_W       = 16;
   localparam int unsigned BLOCKS_W    = 12;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CHUNK_CNT_W = 16;
   // Wide enough for the largest chunk: 4095 blocks of up to 64 bytes.
   localparam int unsigned CHUNK_LEN_W = 18;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [SIZE_REG_W-1:0] IMAGE_SIZE_RESET   = 24'd1;
   localparam logic [CRC_W-1:0]      EXPECTED_CRC_RESET = 16'd0;
   localparam logic [BLOCKS_W-1:0]   CHUNK_BLOCKS_RESET = 12'd62;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_SIZE   = 2'd0,
      CSR_EXPECTED_CRC = 2'd1,
      CSR_CHUNK_BLOCKS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_PROGRESS = 2'd0,
      ST_PASS     = 2'd1,
      ST_FAIL     = 2'd2
   } status_type;

   typedef struct packed {
      logic [SIZE_REG_W-1:0]  image_size;
      logic [CRC_W-1:0]       expected_crc;
      logic [CHUNK_LEN_W-1:0] chunk_len;
   } cfg_type;

   // One byte of reflected CRC-16/ARC, unrolled into eight shift steps.
   function automatic logic [CRC_W-1:0] crc16_arc_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [7:0]       data);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/fic_csr.sv
module fic_csr #(
   parameter int unsigned BLOCK_BYTES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fic_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fic_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output fic_pkg::cfg_type                    cfg
);
   import fic_pkg::*;

   localparam logic [CHUNK_LEN_W-1:0] BLOCK_LEN = CHUNK_LEN_W'(BLOCK_BYTES);

   logic [SIZE_REG_W-1:0]  image_size_ff,   image_size_in;
   logic [CRC_W-1:0]       expected_crc_ff, expected_crc_in;
   logic [CHUNK_LEN_W-1:0] chunk_len_ff,    chunk_len_in;

   // The chunk length in bytes is worked out once, when the block count is written, and from the default at reset.
   always_comb begin
      image_size_in   = image_size_ff;
      expected_crc_in = expected_crc_ff;
      chunk_len_in    = chunk_len_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_SIZE:   image_size_in   = csr_wdata[SIZE_REG_W-1:0];
            CSR_EXPECTED_CRC: expected_crc_in = csr_wdata[CRC_W-1:0];
            CSR_CHUNK_BLOCKS: chunk_len_in    =
               CHUNK_LEN_W'(csr_wdata[BLOCKS_W-1:0]) * BLOCK_LEN;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff   <= IMAGE_SIZE_RESET;
         expected_crc_ff <= EXPECTED_CRC_RESET;
         chunk_len_ff    <= CHUNK_LEN_W'(CHUNK_BLOCKS_RESET) * BLOCK_LEN;
      end else begin
         image_size_ff   <= image_size_in;
         expected_crc_ff <= expected_crc_in;
         chunk_len_ff    <= chunk_len_in;
      end
   end

   assign cfg.image_size   = image_size_ff;
   assign cfg.expected_crc = expected_crc_ff;
   assign cfg.chunk_len    = chunk_len_ff;

endmodule

FILE: sv/fic_in_reg.sv
module fic_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       take,
   output logic       hold_valid,
   output logic [7:0] hold_byte
);
   import fic_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff && !take;
      byte_in  = byte_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         byte_in  = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

FILE: sv/fic_core.sv
module fic_core #(
   parameter int unsigned SIZE_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fic_pkg::cfg_type           cfg,
   input  logic                       hold_valid,
   input  logic [7:0]                 hold_byte,
   output logic                       take,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [fic_pkg::CRC_W-1:0]  rsp_computed_crc
);
   import fic_pkg::*;

   logic [CRC_W-1:0]       crc_ff,   crc_in;
   logic [SIZE_BITS-1:0]   bytes_ff, bytes_in;
   logic [CHUNK_CNT_W-1:0] chunk_ff, chunk_in;
   logic                   out_valid_ff, out_valid_in;
   status_type             out_status_ff, out_status_in;
   logic [CRC_W-1:0]       out_crc_ff, out_crc_in;

   logic [CRC_W-1:0]            crc_next;
   logic [SIZE_BITS-1:0]        count;
   logic [CHUNK_CNT_W-1:0]      chunk;
   logic [SIZE_BITS+SIZE_REG_W-1:0] size_wide;
   logic [SIZE_BITS-1:0]        size_lim;
   logic                        fire;
   logic                        last_byte;
   logic                        chunk_done;

   // The result register is free, or is handing its result over in this cycle.
   assign take = !out_valid_ff || rsp_ready;
   assign fire = hold_valid && take;

   assign crc_next  = crc16_arc_byte(crc_ff, hold_byte);
   assign count     = bytes_ff + 1'b1;
   assign chunk     = chunk_ff + 1'b1;
   assign size_wide = {{SIZE_BITS{1'b0}}, cfg.image_size};
   assign size_lim  = size_wide[SIZE_BITS-1:0];

   assign last_byte  = (count == size_lim);
   // A zero chunk length never matches, and neither does one beyond the counter.
   assign chunk_done = (cfg.chunk_len != '0) &&
                       ({{(CHUNK_LEN_W-CHUNK_CNT_W){1'b0}}, chunk} == cfg.chunk_len);

   always_comb begin
      crc_in        = crc_ff;
      bytes_in      = bytes_ff;
      chunk_in      = chunk_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_crc_in    = out_crc_ff;
      if (fire) begin
         out_crc_in = crc_next;
         if (last_byte) begin
            crc_in        = '0;
            bytes_in      = '0;
            chunk_in      = '0;
            out_valid_in  = 1'b1;
            out_status_in = (crc_next == cfg.expected_crc) ? ST_PASS : ST_FAIL;
         end else begin
            crc_in   = crc_next;
            bytes_in = count;
            if (chunk_done) begin
               chunk_in      = '0;
               out_valid_in  = 1'b1;
               out_status_in = ST_PROGRESS;
            end else begin
               chunk_in = chunk;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         bytes_ff     <= '0;
         chunk_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         bytes_ff     <= bytes_in;
         chunk_ff     <= chunk_in;
         out_valid_ff <= out_valid_in;
      end
      out_status_ff <= out_status_in;
      out_crc_ff    <= out_crc_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_computed_crc = out_crc_ff;

`ifndef SYNTH
   // A completed pass leaves the CRC and both counters cleared.
   a_pass_clears: assert property (@(posedge clock) disable iff (reset)
      fire && last_byte |=> crc_ff == '0 && bytes_ff == '0 && chunk_ff == '0)
      else $error("state not cleared after the final byte of a pass");

   // A progress result restarts the chunk count but keeps the running CRC.
   a_chunk_restart: assert property (@(posedge clock) disable iff (reset)
      fire && !last_byte && chunk_done |=> chunk_ff == '0 && crc_ff == $past(crc_next))
      else $error("chunk count or CRC wrong after a progress result");

   // Any byte that is processed is reported in the result register if one is due.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      fire && (last_byte || chunk_done) |=> out_valid_ff && out_crc_ff == $past(crc_next))
      else $error("result not loaded for a byte that completes a chunk or pass");

   // A processed byte that owes no result, while the receiver is ready, leaves the result valid flag clear.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      fire && !last_byte && !chunk_done && rsp_ready |=> !out_valid_ff)
      else $error("result shown for a byte that owes none");
`endif

endmodule

FILE: sv/flash_image_crc_checker_top.sv
// Transfer   | Handshake                | Payload
// -----------+--------------------------+--------------------------------------
// req        | req_valid / req_ready    | req_data_byte
// rsp        | rsp_valid / rsp_ready    | rsp_status, rsp_computed_crc
// csr        | csr_we (always taken)    | csr_index, csr_wdata
//
// One byte is taken every cycle while the result side is not stalled; a byte's result,
// if any, passes through the input register and then the result register, around the
// unrolled CRC update.
// The CRC, the byte counter and the chunk counter update as the result register loads.
// A stalled result holds the result register; a byte still moves into the input
// register if it is empty, and further bytes wait until the result is taken.
// Synchronous reset clears the counters, the CRC and both valid flags, and loads
// the register defaults (image size 1, expected CRC 0, 62 blocks per chunk).
module flash_image_crc_checker_top #(
   parameter int unsigned SIZE_BITS   = 24,
   parameter int unsigned BLOCK_BYTES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [fic_pkg::CRC_W-1:0]         rsp_computed_crc,
   input  logic                              csr_we,
   input  logic [fic_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fic_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fic_pkg::*;

   cfg_type    cfg;
   logic       take;
   logic       hold_valid;
   logic [7:0] hold_byte;

   fic_csr #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fic_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .take          (take),
      .hold_valid    (hold_valid),
      .hold_byte     (hold_byte)
   );

   fic_core #(
      .SIZE_BITS (SIZE_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .hold_valid       (hold_valid),
      .hold_byte        (hold_byte),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_computed_crc (rsp_computed_crc)
   );

endmodule

FILE: tb/crc_result_checker.sv
module crc_result_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [1:0]                      rsp_status,
   input  logic [fic_pkg::CRC_W-1:0]       rsp_computed_crc,
   input  logic                            csr_we,
   input  logic [fic_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fic_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              pending_results,
   output int                              mismatch_count
);
   import fic_pkg::*;

   localparam int BYTES_PER_BLOCK = 16;

   typedef struct {
      status_type       status;
      logic [CRC_W-1:0] crc;
   } crc_result_type;

   crc_result_type awaited_results[$];

   // Shadow copies of the registers and of the running scan state.
   logic [SIZE_REG_W-1:0]  size_setting;
   logic [CRC_W-1:0]       crc_setting;
   logic [BLOCKS_W-1:0]    blocks_setting;
   logic [CRC_W-1:0]       scan_crc;
   logic [SIZE_REG_W-1:0]  scan_count;
   logic [CHUNK_CNT_W-1:0] chunk_count;

   // Bit-serial form of the reflected update: feedback is the low CRC bit
   // combined with the next data bit, least significant first.
   function automatic logic [CRC_W-1:0] crc_after_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [7:0]       data);
      logic [CRC_W-1:0] r;
      logic             feedback;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         feedback = r[0] ^ data[i];
         r = r >> 1;
         if (feedback) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic note_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : predict_and_compare
      logic [CRC_W-1:0]       next_crc;
      logic [SIZE_REG_W-1:0]  next_count;
      logic [CHUNK_CNT_W-1:0] next_chunk;
      int                     chunk_len;
      crc_result_type         want;
      crc_result_type         entry;

      if (reset) begin
         size_setting   = IMAGE_SIZE_RESET;
         crc_setting    = EXPECTED_CRC_RESET;
         blocks_setting = CHUNK_BLOCKS_RESET;
         scan_crc       = '0;
         scan_count     = '0;
         chunk_count    = '0;
         awaited_results.delete();
         mismatch_count = 0;
         pending_results <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_SIZE: begin
                  size_setting = csr_wdata[SIZE_REG_W-1:0];
               end
               CSR_EXPECTED_CRC: begin
                  crc_setting = csr_wdata[CRC_W-1:0];
               end
               CSR_CHUNK_BLOCKS: begin
                  blocks_setting = csr_wdata[BLOCKS_W-1:0];
               end
               default: begin
               end
            endcase
         end

         if (req_valid && req_ready) begin
            next_crc   = crc_after_byte(scan_crc, req_data_byte);
            next_count = scan_count + 1'b1;
            next_chunk = chunk_count + 1'b1;
            chunk_len  = int'(blocks_setting) * BYTES_PER_BLOCK;
            if (next_count == size_setting) begin
               // The final verdict wins over a chunk boundary on the same byte.
               entry.status = (next_crc == crc_setting) ? ST_PASS : ST_FAIL;
               entry.crc    = next_crc;
               awaited_results.push_back(entry);
               scan_crc    = '0;
               scan_count  = '0;
               chunk_count = '0;
            end else begin
               scan_crc   = next_crc;
               scan_count = next_count;
               if (chunk_len != 0 && int'(next_chunk) == chunk_len) begin
                  entry.status = ST_PROGRESS;
                  entry.crc    = next_crc;
                  awaited_results.push_back(entry);
                  chunk_count = '0;
               end else begin
                  chunk_count = next_chunk;
               end
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               note_mismatch($sformatf("result transfer with nothing awaited (status %0d crc %h)",
                                       rsp_status, rsp_computed_crc));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status) begin
                  note_mismatch($sformatf("status %0d, predicted %0d",
                                          rsp_status, want.status));
               end
               if (rsp_computed_crc !== want.crc) begin
                  note_mismatch($sformatf("computed_crc %h, predicted %h",
                                          rsp_computed_crc, want.crc));
               end
            end
         end

         pending_results <= awaited_results.size();
      end
   end

endmodule

FILE: tb/flash_image_crc_checker_top_test.sv
module flash_image_crc_checker_top_test;
   import fic_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int SETTLE_CYCLES  = 6;
   localparam int LONG_HOLD      = 250;
   localparam int RANDOM_ITEMS   = 1650;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_status;
   logic [CRC_W-1:0]       rsp_computed_crc;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int pending_results;
   int mismatch_count;

   logic [7:0] image_bytes[$];
   int         burst_left = 0;

   // Receiver state.
   logic        hold_request = 1'b0;
   logic        hold_given = 1'b0;
   int          hold_cycles_left = 0;
   int          pattern_left = 0;
   logic [31:0] stall_pattern = '1;

   always #5 clock = ~clock;

   flash_image_crc_checker_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_computed_crc (rsp_computed_crc),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   crc_result_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_computed_crc (rsp_computed_crc),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pending_results  (pending_results),
      .mismatch_count   (mismatch_count)
   );

   // CRC of the image about to be sent, used to pick an expected_crc that passes.
   function automatic logic [CRC_W-1:0] crc_of_image();
      logic [CRC_W-1:0] c;
      c = '0;
      foreach (image_bytes[i]) begin
         c = c ^ {8'h00, image_bytes[i]};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
      end
      return c;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_image(input int size, input logic [CRC_W-1:0] crc, input int blocks);
      write_reg(CSR_IMAGE_SIZE, CSR_DATA_W'(size));
      write_reg(CSR_EXPECTED_CRC, CSR_DATA_W'(crc));
      write_reg(CSR_CHUNK_BLOCKS, CSR_DATA_W'(blocks));
   endtask

   // Offers one byte and returns at the edge of its transfer or after a gap; bursts and gaps
   // are decided here so that every caller gets the same sender behaviour.
   task automatic send_byte(input logic [7:0] value);
      req_valid     <= 1'b1;
      req_data_byte <= value;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(0, 15);
      end
   endtask

   task automatic send_image(input int passes);
      for (int p = 0; p < passes; p++) begin
         foreach (image_bytes[i]) begin
            send_byte(image_bytes[i]);
         end
      end
   endtask

   task automatic fill_image(input int size);
      image_bytes.delete();
      for (int i = 0; i < size; i++) begin
         image_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Waits until every awaited result has arrived and the pipeline is empty.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: a random stall pattern, replaced now and then, with
   // stretches of no stalling and a single long hold-off on request.
   always @(posedge clock) begin
      if (hold_cycles_left != 0) begin
         rsp_ready <= 1'b0;
         hold_cycles_left--;
      end else if (hold_request && !hold_given) begin
         hold_given = 1'b1;
         hold_cycles_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
            pattern_left = $urandom_range(32, 96);
         end
         rsp_ready <= stall_pattern[pattern_left % 32];
         pattern_left--;
      end
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int random_items;
      int size;
      int blocks;
      int passes;
      int pick;
      logic [CRC_W-1:0] crc_value;

      random_items = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: one-byte images whose CRC must be zero; two are sent.
      image_bytes = '{8'h00, 8'hFF};
      send_image(1);
      drain();

      // Lowest settings, then a write to an unused index that must change nothing.
      program_image(1, 16'h0000, 1);
      write_reg(CSR_SPARE_INDEX, 24'h000010);
      image_bytes = '{8'h00};
      send_image(1);
      drain();

      // A chunk boundary on the final byte gives only the verdict.
      fill_image(16);
      image_bytes[0] = 8'h80;
      image_bytes[1] = 8'h01;
      program_image(16, crc_of_image(), 1);
      send_image(1);
      drain();

      // Highest settings; the pass is then shortened to finish it.
      program_image(24'hFFFFFF, 16'hFFFF, 4095);
      fill_image(3);
      send_image(1);
      drain();
      write_reg(CSR_IMAGE_SIZE, 24'd5);
      fill_image(2);
      send_image(1);
      drain();

      // The receiver holds off while a result waits in the result register and the input stalls.
      fill_image(96);
      program_image(96, crc_of_image(), 1);
      hold_request <= 1'b1;
      send_image(1);
      drain();

      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            size = $urandom_range(1, 40);
         end else if (pick <= 8) begin
            size = $urandom_range(41, 200);
         end else begin
            size = $urandom_range(201, 700);
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            blocks = 0;
         end else if (pick <= 6) begin
            blocks = $urandom_range(1, 4);
         end else if (pick == 7) begin
            blocks = $urandom_range(5, 40);
         end else if (pick == 8) begin
            blocks = $urandom_range(41, 4095);
         end else begin
            blocks = $urandom_range(1, 3);
            size = blocks * 16 * $urandom_range(1, 3);
         end
         fill_image(size);
         crc_value = ($urandom_range(0, 3) != 0) ? crc_of_image() : CRC_W'($urandom);
         passes = $urandom_range(1, 3);
         program_image(size, crc_value, blocks);
         send_image(passes);
         random_items += passes * size;
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
